// ===== rtl/block_pool_free_stack_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_POOL_FREE_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_POOL_FREE_STACK_ALLOCATOR_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define BPFSA_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define BPFSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/bpfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfsa_pkg
// Types, widths and codes shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpfsa_pkg;

  // Pool geometry
  localparam int unsigned POOL_BLOCKS = 1024;
  // Stack entries reachable with an 11-bit block count
  localparam int unsigned MEM_DEPTH   = (POOL_BLOCKS < 2048) ? POOL_BLOCKS : 2048;
  localparam int unsigned ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Field widths
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned BS_W   = 25;
  localparam int unsigned GAP_W  = 24;
  localparam int unsigned OFS_W  = 40;
  localparam int unsigned DLT_W  = 16;
  localparam int unsigned SIZE_W = CNT_W + BS_W;
  localparam int unsigned DVD_W  = BS_W + ADDR_W;
  localparam int unsigned IDX_W  = 20;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SIZE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_GROWS_DOWN  = CFG_IDX_W'(3);

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [OFS_W-1:0] block_offset;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [OFS_W-1:0] alloc_offset;
    logic [BS_W-1:0]  usable_size;
  } out_item_t;

  // Free stack memory port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DLT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/bpfsa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// bpfsa_stack_mem
// Free stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpfsa_stack_mem (
  input  wire logic                           clk_i,
  input  wire bpfsa_pkg::mem_req_t            req_i,
  output logic [bpfsa_pkg::DLT_W-1:0]         rdata_o
);

  logic [bpfsa_pkg::DLT_W-1:0] mem_q [bpfsa_pkg::MEM_DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfsa_div.sv =====
// ----------------------------------------------------------------------------
// bpfsa_div
// Restoring divider, one quotient bit per cycle, for offset to block index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpfsa_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [bpfsa_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [bpfsa_pkg::BS_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic [bpfsa_pkg::ADDR_W-1:0]        quot_o
);

  localparam int unsigned QW     = bpfsa_pkg::ADDR_W;
  localparam int unsigned DSR_W  = bpfsa_pkg::BS_W + QW - 1;
  localparam int unsigned STEP_W = $clog2(QW + 1);

  logic                              busy_q;
  logic                              done_q;
  logic [STEP_W-1:0]                 step_q;
  logic [bpfsa_pkg::DVD_W-1:0]       rem_q;
  logic [DSR_W-1:0]                  dsr_q;
  logic [QW-1:0]                     quot_q;
  logic [bpfsa_pkg::DVD_W-1:0]       dsr_ext;
  logic                              fits;

  assign dsr_ext = bpfsa_pkg::DVD_W'(dsr_q);
  assign fits    = (rem_q >= dsr_ext);

  // Control: count quotient bits, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QW);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract the shifted divisor where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= DSR_W'({divisor_i, {(QW - 1){1'b0}}});
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsr_ext;
      end
      quot_q <= QW'({quot_q, fits});
      dsr_q  <= dsr_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/block_pool_free_stack_allocator_core.sv =====
// ----------------------------------------------------------------------------
// block_pool_free_stack_allocator_core
// Fixed-block pool allocator on a free stack of index deltas.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Dir | Handshake
//  in      | in_valid_i in_ready_o in_item_i         | in  | valid/ready
//  out     | out_valid_o out_ready_i out_item_o      | out | valid/ready
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data| in  | valid/ready
//
//  After reset a clearing pass zeroes the stack, one entry a cycle, over all
//  MEM_DEPTH entries (1024); no item is taken then, configuration writes are.
//  Alloc steps: stack read, index map, offset multiply, hand off.
//  Free steps: pool size, range check, one-bit-a-cycle divide, push, hand off.
//  One item is in work at a time; a finished result waits in the output
//  register while the next item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_pool_free_stack_allocator_core_assert.svh"

module block_pool_free_stack_allocator_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire bpfsa_pkg::in_item_t               in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output bpfsa_pkg::out_item_t                   out_item_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bpfsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bpfsa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W  = bpfsa_pkg::CNT_W;
  localparam int unsigned BS_W   = bpfsa_pkg::BS_W;
  localparam int unsigned GAP_W  = bpfsa_pkg::GAP_W;
  localparam int unsigned OFS_W  = bpfsa_pkg::OFS_W;
  localparam int unsigned DLT_W  = bpfsa_pkg::DLT_W;
  localparam int unsigned ADDR_W = bpfsa_pkg::ADDR_W;
  localparam int unsigned SIZE_W = bpfsa_pkg::SIZE_W;
  localparam int unsigned DVD_W  = bpfsa_pkg::DVD_W;
  localparam int unsigned IDX_W  = bpfsa_pkg::IDX_W;

  // State codes
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_AMUL  = 4'd3;
  localparam logic [3:0] S_FSIZE = 4'd4;
  localparam logic [3:0] S_FCMP  = 4'd5;
  localparam logic [3:0] S_FDIV  = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [CNT_W-1:0]        sp_q, sp_d;
  logic [OFS_W-1:0]        ofs_q, ofs_d;
  logic [SIZE_W-1:0]       size_q, size_d;
  logic [ADDR_W-1:0]       idx_q, idx_d;
  bpfsa_pkg::out_item_t    res_q, res_d;
  bpfsa_pkg::out_item_t    out_q;
  logic                    out_valid_q;

  logic [CNT_W-1:0]        cnt_cfg_q;
  logic [BS_W-1:0]         bs_q;
  logic [GAP_W-1:0]        gap_q;
  logic                    down_q;

  logic [CNT_W-1:0]        cnt_eff;
  logic                    in_fire;
  logic                    out_load;
  bpfsa_pkg::mem_req_t     mem_req;
  logic [DLT_W-1:0]        mem_rdata;
  logic                    div_start;
  logic                    div_done;
  logic [ADDR_W-1:0]       div_quot;

  logic [CNT_W-1:0]        pop_pos;
  logic signed [IDX_W-1:0] pop_idx;
  logic signed [IDX_W-1:0] map_idx;
  logic signed [IDX_W-1:0] cnt_s;
  logic [ADDR_W+BS_W-1:0]  prod;
  logic [CNT_W-1:0]        free_idx;
  logic [CNT_W-1:0]        free_pos;
  logic [CNT_W-1:0]        bidx;

  // Clamp the block count to the stack depth
  assign cnt_eff = ({1'b0, cnt_cfg_q} > (CNT_W + 1)'(bpfsa_pkg::MEM_DEPTH))
                 ? CNT_W'(bpfsa_pkg::MEM_DEPTH) : cnt_cfg_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q <= CNT_W'(1024);
      bs_q      <= BS_W'(8388608);
      gap_q     <= GAP_W'(4096);
      down_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpfsa_pkg::CFG_BLOCK_COUNT: cnt_cfg_q <= cfg_data_i[CNT_W-1:0];
        bpfsa_pkg::CFG_BLOCK_SIZE:  bs_q      <= cfg_data_i[BS_W-1:0];
        bpfsa_pkg::CFG_GAP_SIZE:    gap_q     <= cfg_data_i[GAP_W-1:0];
        bpfsa_pkg::CFG_GROWS_DOWN:  down_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Map a popped delta to a block index
  assign pop_pos = sp_q - CNT_W'(1);
  assign cnt_s   = $signed({{(IDX_W - CNT_W){1'b0}}, cnt_eff});
  assign pop_idx = $signed({{(IDX_W - DLT_W){mem_rdata[DLT_W-1]}}, mem_rdata})
                 + $signed({{(IDX_W - CNT_W){1'b0}}, pop_pos});
  assign map_idx = down_q ? (cnt_s - pop_idx) : pop_idx;

  // Offset of the allocated block
  assign prod = idx_q * bs_q;

  // Push position and mapped index of a freed block
  assign bidx     = CNT_W'(div_quot);
  assign free_pos = sp_q - CNT_W'(1);
  assign free_idx = down_q ? (cnt_eff - bidx) : bidx;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    sp_d      = sp_q;
    ofs_d     = ofs_q;
    size_d    = size_q;
    idx_d     = idx_q;
    res_d     = res_q;
    div_start = 1'b0;
    mem_req   = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        mem_req.wdata = '0;
        clr_d         = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(bpfsa_pkg::MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_d.status       = bpfsa_pkg::ST_OK;
          res_d.alloc_offset = '0;
          res_d.usable_size  = '0;
          ofs_d              = in_item_i.block_offset;
          if (in_item_i.mode) begin
            state_d = S_FSIZE;
          end else if (sp_q < cnt_eff) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = sp_q[ADDR_W-1:0];
            sp_d          = sp_q + CNT_W'(1);
            state_d       = S_ARD;
          end else begin
            res_d.status = bpfsa_pkg::ST_EMPTY;
            state_d      = S_FIN;
          end
        end
      end
      S_ARD: begin
        idx_d = map_idx[ADDR_W-1:0];
        if (map_idx > 0 && map_idx < cnt_s) begin
          state_d = S_AMUL;
        end else begin
          res_d.status = bpfsa_pkg::ST_EMPTY;
          state_d      = S_FIN;
        end
      end
      S_AMUL: begin
        res_d.alloc_offset = OFS_W'(prod);
        res_d.usable_size  = ({1'b0, gap_q} < bs_q) ? (bs_q - {1'b0, gap_q}) : '0;
        state_d            = S_FIN;
      end
      S_FSIZE: begin
        size_d  = cnt_eff * bs_q;
        state_d = S_FCMP;
      end
      S_FCMP: begin
        if (ofs_q >= OFS_W'(size_q) || sp_q <= CNT_W'(1)) begin
          res_d.status = bpfsa_pkg::ST_IGNORED;
          state_d      = S_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        if (bidx == '0 || bidx >= cnt_eff) begin
          res_d.status = bpfsa_pkg::ST_IGNORED;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = free_pos[ADDR_W-1:0];
          mem_req.wdata = DLT_W'(free_idx) - DLT_W'(free_pos);
          sp_d          = free_pos;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sp_q    <= CNT_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    ofs_q  <= ofs_d;
    size_q <= size_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  // Hold the result until the consumer takes it
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  bpfsa_stack_mem u_stack (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bpfsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ofs_q[DVD_W-1:0]),
    .divisor_i  (bs_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Stack pointer stays within the base and the stack depth
  `BPFSA_ASSERT_HOLDS(a_sp_range, (sp_q >= CNT_W'(1) && {1'b0, sp_q} <= (CNT_W + 1)'(bpfsa_pkg::MEM_DEPTH)), "stack pointer out of range")
  // Only the clearing pass and a push write the stack
  `BPFSA_ASSERT_HOLDS(a_we_state, (!mem_req.we || state_q == S_CLEAR || state_q == S_FWR), "stack write outside clear or push")
  // A pop with room advances the pointer by one
  `BPFSA_ASSERT_NEXT(a_pop_sp, (in_fire && !in_item_i.mode && sp_q < cnt_eff), (sp_q == $past(sp_q) + CNT_W'(1)), "pop did not advance stack pointer")
  // A push lowers the pointer by one
  `BPFSA_ASSERT_NEXT(a_push_sp, (state_q == S_FWR && mem_req.we), (sp_q == $past(sp_q) - CNT_W'(1)), "push did not lower stack pointer")
  // The divider finishes only while the sequencer waits for it
  `BPFSA_ASSERT_HOLDS(a_div_done, (!div_done || state_q == S_FDIV), "divider done outside wait state")

endmodule

`default_nettype wire
